// File: hdl/sscwa_pkg.sv
// Package with constants and helper functions for the seven-segment clock with alarm.
`default_nettype none

package sscwa_pkg;

   localparam int unsigned CountWidth = 16;
   localparam int unsigned TimeWidth  = 6;
   localparam int unsigned DigitWidth = 3;
   localparam int unsigned SegWidth   = 8;
   localparam int unsigned CsrIdxWidth = 8;

   localparam logic [TimeWidth-1:0]  MaxTime         = 6'd59;
   localparam logic [CountWidth-1:0] TicksPerSecRst  = 16'd1000;
   localparam logic [CountWidth-1:0] KeyScanRst      = 16'd301;
   localparam logic [SegWidth-1:0]   DecimalPoint    = 8'h80;

   localparam logic [CsrIdxWidth-1:0] CsrTicksPerSecond = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CsrKeyScanPeriod  = 8'd1;

   localparam logic [DigitWidth-1:0] DigClkSecUnits = 3'd0;
   localparam logic [DigitWidth-1:0] DigClkSecTens  = 3'd1;
   localparam logic [DigitWidth-1:0] DigClkMinUnits = 3'd2;
   localparam logic [DigitWidth-1:0] DigClkMinTens  = 3'd3;
   localparam logic [DigitWidth-1:0] DigAlmSecUnits = 3'd4;
   localparam logic [DigitWidth-1:0] DigAlmSecTens  = 3'd5;
   localparam logic [DigitWidth-1:0] DigAlmMinUnits = 3'd6;

   typedef struct packed {
      logic [2:0] tens;
      logic [3:0] units;
   } bcd_type;

   function automatic logic [SegWidth-1:0] font_of(input logic [3:0] digit);
      logic [SegWidth-1:0] seg;
      case (digit)
         4'd0:    seg = 8'h3f;
         4'd1:    seg = 8'h06;
         4'd2:    seg = 8'h5b;
         4'd3:    seg = 8'h4f;
         4'd4:    seg = 8'h66;
         4'd5:    seg = 8'h6d;
         4'd6:    seg = 8'h7d;
         4'd7:    seg = 8'h07;
         4'd8:    seg = 8'h7f;
         4'd9:    seg = 8'h6f;
         default: seg = 8'h00;
      endcase
      return seg;
   endfunction

   function automatic bcd_type split_bcd(input logic [TimeWidth-1:0] v);
      bcd_type r;
      logic [TimeWidth-1:0] base;
      if (v >= 6'd60) begin
         r.tens = 3'd6; base = 6'd60;
      end else if (v >= 6'd50) begin
         r.tens = 3'd5; base = 6'd50;
      end else if (v >= 6'd40) begin
         r.tens = 3'd4; base = 6'd40;
      end else if (v >= 6'd30) begin
         r.tens = 3'd3; base = 6'd30;
      end else if (v >= 6'd20) begin
         r.tens = 3'd2; base = 6'd20;
      end else if (v >= 6'd10) begin
         r.tens = 3'd1; base = 6'd10;
      end else begin
         r.tens = 3'd0; base = 6'd0;
      end
      r.units = 4'(v - base);
      return r;
   endfunction

   function automatic logic [TimeWidth-1:0] bump_wrap(input logic [TimeWidth-1:0] v);
      logic [TimeWidth-1:0] n;
      n = v + 6'd1;
      return (n > MaxTime) ? '0 : n;
   endfunction

endpackage

`default_nettype wire

// File: hdl/seven_segment_clock_with_alarm_top.sv
// Top level of the multiplexed seven-segment clock with alarm.
//
//   Channel  Direction  Payload
//   req_     in         one tick with six active-low button levels
//   rsp_     out        segments, digit select and alarm LED for that tick
//   csr_     in         register index and 16-bit write data
//
// One tick is accepted per clock cycle; the input side stalls only while a
// result is held and the output side is not ready. Results appear in the
// output register on the next cycle. The state update and the display decode
// are a single pass of logic from the state registers into the output
// register. Reset clears all but seg_ff and dsel_ff and loads default periods.
`default_nettype none

module seven_segment_clock_with_alarm_top
   import sscwa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // Fields from bit 0: btn_clock_sec_n, btn_clock_min_n, btn_alarm_sec_n,
   // btn_alarm_min_n, btn_restore_n, btn_save_n, two zero bits.
   input  wire logic [7:0]  req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // Fields from bit 0: segments[7:0], digit_select[15:8], alarm_led[16],
   // seven zero bits.
   output logic [23:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [CountWidth-1:0]  csr_data
);

   logic [CountWidth-1:0] tps_ff, ksp_ff;
   logic [CountWidth-1:0] tick_count_ff, tick_count_in;
   logic [CountWidth-1:0] scan_count_ff, scan_count_in;
   logic [DigitWidth-1:0] digit_index_ff, digit_index_in;
   logic [TimeWidth-1:0]  clk_sec_ff, clk_sec_in, clk_min_ff, clk_min_in;
   logic [TimeWidth-1:0]  alm_sec_ff, alm_sec_in, alm_min_ff, alm_min_in;
   logic [TimeWidth-1:0]  bak_sec_ff, bak_sec_in, bak_min_ff, bak_min_in;
   logic                  saved_ff, saved_in, armed_ff, armed_in;
   logic                  latch_ff, latch_in;
   logic                  rsp_valid_ff;
   logic [SegWidth-1:0]   seg_ff, seg_in;
   logic [7:0]            dsel_ff, dsel_in;

   logic                  req_accept;
   logic                  p_csec, p_cmin, p_asec, p_amin, p_rest, p_save;
   logic [CountWidth:0]   scan_next, tick_next;
   logic [TimeWidth-1:0]  sec_a, sec_b, min_a, min_b;
   bcd_type               bcd_clk_sec, bcd_clk_min, bcd_alm_sec, bcd_alm_min;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, latch_ff, dsel_ff, seg_ff};

   assign p_csec = !req_tdata[0];
   assign p_cmin = !req_tdata[1];
   assign p_asec = !req_tdata[2];
   assign p_amin = !req_tdata[3];
   assign p_rest = !req_tdata[4];
   assign p_save = !req_tdata[5];

   always_comb begin
      scan_next = {1'b0, scan_count_ff} + 17'd1;
      scan_count_in = (scan_next >= {1'b0, ksp_ff}) ? '0 : scan_next[CountWidth-1:0];

      digit_index_in = digit_index_ff + 3'd1;

      tick_next = {1'b0, tick_count_ff} + 17'd1;
      sec_a = clk_sec_ff;
      if (tick_next >= {1'b0, tps_ff}) begin
         tick_count_in = '0;
         sec_a = clk_sec_ff + 6'd1;
      end else begin
         tick_count_in = tick_next[CountWidth-1:0];
      end
      sec_b = sec_a;
      min_a = clk_min_ff;
      if (sec_a > MaxTime) begin
         sec_b = '0;
         min_a = clk_min_ff + 6'd1;
      end
      min_b = (min_a > MaxTime) ? MaxTime : min_a;

      bcd_clk_sec = split_bcd(sec_b);
      bcd_clk_min = split_bcd(min_b);
      bcd_alm_sec = split_bcd(alm_sec_ff);
      bcd_alm_min = split_bcd(alm_min_ff);

      case (digit_index_in)
         DigClkSecUnits: seg_in = font_of(bcd_clk_sec.units);
         DigClkSecTens:  seg_in = font_of({1'b0, bcd_clk_sec.tens});
         DigClkMinUnits: seg_in = font_of(bcd_clk_min.units);
         DigClkMinTens:  seg_in = font_of({1'b0, bcd_clk_min.tens});
         DigAlmSecUnits: seg_in = font_of(bcd_alm_sec.units) | (saved_ff ? DecimalPoint : '0);
         DigAlmSecTens:  seg_in = font_of({1'b0, bcd_alm_sec.tens});
         DigAlmMinUnits: seg_in = font_of(bcd_alm_min.units);
         default:        seg_in = font_of({1'b0, bcd_alm_min.tens})
                                  | (armed_ff ? DecimalPoint : '0);
      endcase
      dsel_in = 8'(~(8'd1 << digit_index_in));

      clk_sec_in = sec_b;
      clk_min_in = min_b;
      alm_sec_in = alm_sec_ff;
      alm_min_in = alm_min_ff;
      bak_sec_in = bak_sec_ff;
      bak_min_in = bak_min_ff;
      saved_in   = saved_ff;
      armed_in   = armed_ff;
      if (scan_count_in == '0) begin
         if (p_csec) clk_sec_in = bump_wrap(clk_sec_in);
         if (p_cmin) clk_min_in = bump_wrap(clk_min_in);
         if (p_asec) alm_sec_in = bump_wrap(alm_sec_in);
         if (p_amin) alm_min_in = bump_wrap(alm_min_in);
         if (p_save) begin
            bak_sec_in = alm_sec_in;
            bak_min_in = alm_min_in;
            saved_in   = 1'b1;
         end
         if (p_rest) begin
            alm_sec_in = bak_sec_in;
            alm_min_in = bak_min_in;
            armed_in   = 1'b1;
         end
      end
      latch_in = latch_ff || (armed_in && clk_sec_in == alm_sec_in
                              && clk_min_in == alm_min_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TicksPerSecRst;
         ksp_ff <= KeyScanRst;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CsrTicksPerSecond) tps_ff <= csr_data;
         if (csr_index == CsrKeyScanPeriod)  ksp_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff  <= '0;
         scan_count_ff  <= '0;
         digit_index_ff <= '0;
         clk_sec_ff     <= '0;
         clk_min_ff     <= '0;
         alm_sec_ff     <= '0;
         alm_min_ff     <= '0;
         bak_sec_ff     <= '0;
         bak_min_ff     <= '0;
         saved_ff       <= 1'b0;
         armed_ff       <= 1'b0;
         latch_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else if (req_accept) begin
         tick_count_ff  <= tick_count_in;
         scan_count_ff  <= scan_count_in;
         digit_index_ff <= digit_index_in;
         clk_sec_ff     <= clk_sec_in;
         clk_min_ff     <= clk_min_in;
         alm_sec_ff     <= alm_sec_in;
         alm_min_ff     <= alm_min_in;
         bak_sec_ff     <= bak_sec_in;
         bak_min_ff     <= bak_min_in;
         saved_ff       <= saved_in;
         armed_ff       <= armed_in;
         latch_ff       <= latch_in;
         rsp_valid_ff   <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         seg_ff  <= seg_in;
         dsel_ff <= dsel_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/sscwa_checker.sv
// Port checker for the seven-segment clock with alarm, bound to the top level.
`default_nettype none

module sscwa_checker
   import sscwa_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // A result that is not taken stays unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Exactly one digit is selected.
   a_one_cold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(~rsp_tdata[15:8]) == 1)
      else $error("digit select is not one-cold");

   // Once the alarm LED is on, it stays on until reset.
   a_led_latched: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |=> !rsp_tvalid || rsp_tdata[16])
      else $error("alarm LED dropped");

   // The input side only stalls behind a waiting result.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   // Decimal points appear only on digits 4 and 7.
   a_point_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[15:8] != 8'hef && rsp_tdata[15:8] != 8'h7f
      |-> !rsp_tdata[7])
      else $error("decimal point on an unexpected digit");

endmodule

bind seven_segment_clock_with_alarm_top sscwa_checker u_sscwa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the seven-segment clock with alarm, run on ticks of random buttons.

module testbench
   import sscwa_pkg::*;
;

   localparam int BtnClockSec = 0;
   localparam int BtnClockMin = 1;
   localparam int BtnAlarmSec = 2;
   localparam int BtnAlarmMin = 3;
   localparam int BtnRestore  = 4;
   localparam int BtnSave     = 5;

   localparam logic [5:0] AllReleased = 6'h3f;
   localparam int unsigned TickTarget = 1900;
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned PrintLimit = 40;

   typedef struct packed {
      logic [SegWidth-1:0] segments;
      logic [7:0]          digit_select;
      logic                alarm_led;
   } display_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata = 8'h00;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CsrIdxWidth-1:0] csr_index = '0;
   logic [CountWidth-1:0]  csr_data = '0;

   // Predicted state of the clock, updated once per accepted tick.
   logic [CountWidth-1:0] cfg_ticks_per_sec = TicksPerSecRst;
   logic [CountWidth-1:0] cfg_scan_period   = KeyScanRst;
   logic [CountWidth-1:0] tick_ctr  = '0;
   logic [CountWidth-1:0] scan_ctr  = '0;
   logic [DigitWidth-1:0] digit_pos = '0;
   logic [TimeWidth-1:0]  clk_sec = '0;
   logic [TimeWidth-1:0]  clk_min = '0;
   logic [TimeWidth-1:0]  alm_sec = '0;
   logic [TimeWidth-1:0]  alm_min = '0;
   logic [TimeWidth-1:0]  bak_sec = '0;
   logic [TimeWidth-1:0]  bak_min = '0;
   logic                  saved_flag   = 1'b0;
   logic                  armed_flag   = 1'b0;
   logic                  led_latched  = 1'b0;

   logic [5:0]  pending_ticks[$];
   display_type expected_display[$];

   int unsigned ticks_queued = 0;
   int unsigned ticks_sent = 0;
   int unsigned results_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned hold_cycles = 0;
   bit          backpressure_done = 1'b0;
   bit          chase_done = 1'b0;

   seven_segment_clock_with_alarm_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [SegWidth-1:0] glyph(input logic [TimeWidth-1:0] value,
                                                 input bit tens_place);
      logic [TimeWidth-1:0] digit;
      logic [SegWidth-1:0]  pattern;
      digit = tens_place ? value / 6'd10 : value % 6'd10;
      case (digit)
         6'd0:    pattern = 8'h3f;
         6'd1:    pattern = 8'h06;
         6'd2:    pattern = 8'h5b;
         6'd3:    pattern = 8'h4f;
         6'd4:    pattern = 8'h66;
         6'd5:    pattern = 8'h6d;
         6'd6:    pattern = 8'h7d;
         6'd7:    pattern = 8'h07;
         6'd8:    pattern = 8'h7f;
         6'd9:    pattern = 8'h6f;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

   function automatic logic [TimeWidth-1:0] next_time(input logic [TimeWidth-1:0] value);
      return (value >= MaxTime) ? '0 : value + 6'd1;
   endfunction

   function automatic logic [5:0] pressing(input int btn);
      return AllReleased & ~(6'd1 << btn);
   endfunction

   function automatic void predict_tick(input logic [5:0] buttons_n);
      logic [16:0]         bumped;
      logic [SegWidth-1:0] seg;
      logic [5:0]          pressed;
      display_type         want;
      pressed = ~buttons_n;
      bumped = {1'b0, scan_ctr} + 17'd1;
      scan_ctr = (bumped >= {1'b0, cfg_scan_period}) ? '0 : bumped[15:0];
      digit_pos = digit_pos + 3'd1;
      bumped = {1'b0, tick_ctr} + 17'd1;
      if (bumped >= {1'b0, cfg_ticks_per_sec}) begin
         tick_ctr = '0;
         clk_sec = clk_sec + 6'd1;
      end else begin
         tick_ctr = bumped[15:0];
      end
      if (clk_sec > MaxTime) begin
         clk_sec = '0;
         clk_min = clk_min + 6'd1;
      end
      if (clk_min > MaxTime) clk_min = MaxTime;
      case (digit_pos)
         DigClkSecUnits: seg = glyph(clk_sec, 1'b0);
         DigClkSecTens:  seg = glyph(clk_sec, 1'b1);
         DigClkMinUnits: seg = glyph(clk_min, 1'b0);
         DigClkMinTens:  seg = glyph(clk_min, 1'b1);
         DigAlmSecUnits: seg = glyph(alm_sec, 1'b0) | (saved_flag ? DecimalPoint : 8'h00);
         DigAlmSecTens:  seg = glyph(alm_sec, 1'b1);
         DigAlmMinUnits: seg = glyph(alm_min, 1'b0);
         default:        seg = glyph(alm_min, 1'b1) | (armed_flag ? DecimalPoint : 8'h00);
      endcase
      want.segments = seg;
      want.digit_select = ~(8'd1 << digit_pos);
      if (scan_ctr == '0) begin
         if (pressed[BtnClockSec]) clk_sec = next_time(clk_sec);
         if (pressed[BtnClockMin]) clk_min = next_time(clk_min);
         if (pressed[BtnAlarmSec]) alm_sec = next_time(alm_sec);
         if (pressed[BtnAlarmMin]) alm_min = next_time(alm_min);
         if (pressed[BtnSave]) begin
            bak_sec = alm_sec;
            bak_min = alm_min;
            saved_flag = 1'b1;
         end
         if (pressed[BtnRestore]) begin
            alm_sec = bak_sec;
            alm_min = bak_min;
            armed_flag = 1'b1;
         end
      end
      if (armed_flag && clk_sec == alm_sec && clk_min == alm_min) led_latched = 1'b1;
      want.alarm_led = led_latched;
      expected_display.push_back(want);
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      mismatches++;
      if (mismatches <= PrintLimit)
         $display("mismatch at result %0d: %s is %0h, expected %0h",
                  results_seen, what, got, want);
   endtask

   task automatic check_display(input logic [23:0] beat);
      display_type want;
      if (expected_display.size() == 0) begin
         flag_mismatch("result with no tick outstanding", beat, 0);
      end else begin
         want = expected_display.pop_front();
         if (beat[7:0] !== want.segments)
            flag_mismatch("segments", beat[7:0], want.segments);
         if (beat[15:8] !== want.digit_select)
            flag_mismatch("digit_select", beat[15:8], want.digit_select);
         if (beat[16] !== want.alarm_led)
            flag_mismatch("alarm_led", beat[16], want.alarm_led);
      end
   endtask

   // Tick driver: the head of the pending queue stays on the bus until accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= 8'h00;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_tick(req_tdata[5:0]);
            void'(pending_ticks.pop_front());
            ticks_sent++;
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else if (pending_ticks.size() != 0 &&
                      !((ticks_sent < 600 || ticks_sent >= 900) &&
                        $urandom_range(99) < 7)) begin
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, pending_ticks[0]};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Display monitor with random stalls and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_display(rsp_tdata);
            results_seen++;
         end
         if (hold_cycles != 0) begin
            hold_cycles--;
         end else if (!backpressure_done && results_seen >= 400) begin
            hold_cycles = 80;
            backpressure_done = 1'b1;
         end
         rsp_tready <= (hold_cycles == 0) &&
                       !((results_seen < 1000 || results_seen >= 1300) &&
                         $urandom_range(99) < 7);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   task automatic write_csr(input logic [CsrIdxWidth-1:0] idx,
                            input logic [CountWidth-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CsrTicksPerSecond) cfg_ticks_per_sec = value;
      else if (idx == CsrKeyScanPeriod) cfg_scan_period = value;
   endtask

   task automatic queue_ticks(input logic [5:0] buttons, input int unsigned count);
      @(negedge clock);
      repeat (count) pending_ticks.push_back(buttons);
      ticks_queued += count;
   endtask

   // Holds whole scan periods, exactly one action each, if the period is at most 8, else 1-8 ticks.
   task automatic hold_presses(input logic [5:0] buttons, input int unsigned presses);
      int unsigned period;
      period = (cfg_scan_period == 0) ? 1 : cfg_scan_period;
      if (period <= 8) queue_ticks(buttons, presses * period);
      else queue_ticks(buttons, $urandom_range(1, 8));
   endtask

   task automatic settle();
      while (pending_ticks.size() != 0 || expected_display.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [CountWidth-1:0] pick_period();
      case ($urandom_range(0, 19))
         0:       return 16'd0;
         1:       return 16'hffff;
         2:       return 16'($urandom_range(1, 65535));
         3:       return 16'($urandom_range(7, 300));
         default: return 16'($urandom_range(1, 6));
      endcase
   endfunction

   // Sets the alarm and clock minutes to 59 with the clock frozen, arms the
   // compare, then lets the saturated minute sweep through the alarm seconds.
   task automatic chase_alarm();
      settle();
      write_csr(CsrTicksPerSecond, 16'hffff);
      write_csr(CsrKeyScanPeriod, 16'($urandom_range(1, 3)));
      hold_presses(pressing(BtnAlarmSec), $urandom_range(0, 5));
      hold_presses(pressing(BtnAlarmMin), MaxTime - alm_min);
      hold_presses(pressing(BtnSave) & pressing(BtnRestore), 1);
      hold_presses(pressing(BtnClockMin), MaxTime - clk_min);
      settle();
      write_csr(CsrTicksPerSecond, 16'($urandom_range(1, 2)));
      queue_ticks(AllReleased, 61 * cfg_ticks_per_sec + 8);
      chase_done = 1'b1;
   endtask

   task automatic random_phase();
      int unsigned phase_end;
      logic [5:0]  buttons;
      settle();
      if ($urandom_range(0, 3) != 0) write_csr(CsrTicksPerSecond, pick_period());
      if ($urandom_range(0, 3) != 0) write_csr(CsrKeyScanPeriod, pick_period());
      if ($urandom_range(0, 4) == 0)
         write_csr(8'($urandom_range(2, 255)), 16'($urandom));
      phase_end = ticks_queued + $urandom_range(60, 200);
      while (ticks_queued < phase_end) begin
         case ($urandom_range(0, 9))
            0, 1: queue_ticks(AllReleased, $urandom_range(1, 30));
            2, 3, 4: hold_presses(pressing($urandom_range(BtnClockSec, BtnAlarmMin)),
                                  $urandom_range(1, 5));
            5: hold_presses(pressing(BtnSave), 1);
            6: begin
               buttons = pressing(BtnRestore);
               if ($urandom_range(0, 1) != 0) buttons = buttons & pressing(BtnSave);
               hold_presses(buttons, 1);
            end
            7: begin
               repeat ($urandom_range(1, 10)) queue_ticks(6'($urandom), 1);
            end
            default: begin
               buttons = {2'b11, 4'($urandom)};
               hold_presses(buttons, $urandom_range(1, 3));
            end
         endcase
      end
   endtask

   initial begin
      int unsigned waited;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Periods at their reset values: the buttons are not yet sampled.
      queue_ticks(AllReleased, 1);
      queue_ticks(6'h00, 1);
      queue_ticks(6'h15, 1);

      // Frozen clock, buttons sampled every tick: each button and the
      // save-then-restore ordering when both are pressed together.
      settle();
      write_csr(CsrTicksPerSecond, 16'hffff);
      write_csr(CsrKeyScanPeriod, 16'd1);
      write_csr(CsrKeyScanPeriod + 8'd1, 16'h0005);
      queue_ticks(pressing(BtnClockMin), 1);
      queue_ticks(pressing(BtnClockSec), 1);
      queue_ticks(pressing(BtnAlarmSec), 1);
      queue_ticks(6'h30, 1);
      queue_ticks(pressing(BtnAlarmMin), 1);
      queue_ticks(pressing(BtnSave), 1);
      queue_ticks(6'h03, 1);
      queue_ticks(pressing(BtnRestore), 1);

      // Zero periods behave as one.
      settle();
      write_csr(CsrTicksPerSecond, 16'd0);
      write_csr(CsrKeyScanPeriod, 16'd0);
      queue_ticks(AllReleased, 1);
      queue_ticks(pressing(BtnClockSec), 1);
      queue_ticks(pressing(BtnAlarmSec), 1);
      queue_ticks(AllReleased, 1);

      // Counters run up under long periods, then the periods drop below them.
      settle();
      write_csr(CsrTicksPerSecond, 16'hffff);
      write_csr(CsrKeyScanPeriod, 16'hffff);
      repeat (6) queue_ticks(6'($urandom), 1);
      settle();
      write_csr(CsrTicksPerSecond, 16'd3);
      write_csr(CsrKeyScanPeriod, 16'd2);
      queue_ticks(pressing(BtnAlarmSec), 1);
      queue_ticks(AllReleased, 1);
      queue_ticks(pressing(BtnClockSec), 1);
      queue_ticks(AllReleased, 2);

      while (ticks_queued < TickTarget) begin
         if (!chase_done && !led_latched && ticks_queued >= 1000) chase_alarm();
         random_phase();
      end

      while (pending_ticks.size() != 0) @(negedge clock);
      waited = 0;
      while (expected_display.size() != 0 && waited < 50) begin
         @(negedge clock);
         waited++;
      end
      repeat (4) @(negedge clock);
      if (expected_display.size() != 0)
         flag_mismatch("results never delivered", 0, expected_display.size());
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
